// ===== rtl/page_table_demand_allocator_assert.svh =====
// Assertion macros shared by the page table allocator RTL.
`ifndef PAGE_TABLE_DEMAND_ALLOCATOR_ASSERT_SVH
`define PAGE_TABLE_DEMAND_ALLOCATOR_ASSERT_SVH
// Checks that a condition holds at every clock edge outside reset.
`define PTDA_ASSERT(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a trigger implies a consequence in the next cycle.
`define PTDA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);
`endif

// ===== rtl/ptda_pkg.sv =====
// Package with constants and types of the page table allocator.
`default_nettype none
package ptda_pkg;
	localparam int TASKS = 16;
	localparam int VIRT_PAGES = 1024;
	localparam int FRAMES = 256;
	localparam int PAGE_BYTES = 4096;
	localparam int MAX_REQ_PAGES = 256;
	localparam int CNT_W = 9;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_PAGE  = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_TOTAL = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/ptda_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ptda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/page_table_demand_allocator.sv =====
// Per page the FSM runs ST_READ and ST_PAGE, plus ST_SCAN when a frame is newly mapped.
// One request is handled at a time; the next can be taken in the cycle after the result transfer.
// The scan pointer always rests on the lowest free frame, so a new page needs no search.
// After reset a clearing pass runs over the valid, free and totals memories;
// no request is taken until it ends.
// The asynchronous active-low reset initialises state, pointers, counters and out_v_q.
`default_nettype none
`include "page_table_demand_allocator_assert.svh"
module page_table_demand_allocator #(
	parameter int TASKS = ptda_pkg::TASKS,
	parameter int VIRT_PAGES = ptda_pkg::VIRT_PAGES,
	parameter int FRAMES = ptda_pkg::FRAMES,
	parameter int PAGE_BYTES = ptda_pkg::PAGE_BYTES,
	parameter int MAX_REQ_PAGES = ptda_pkg::MAX_REQ_PAGES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// task_num[3:0], virt_address[35:4], byte_length[56:36], zero fill to 64
	input  wire logic [63:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// hit_pages[8:0], mapped_pages[17:9], failed_pages[26:18],
	// task_hit_total[58:27], task_page_total[90:59], frames_left[99:91], zero fill to 104
	output logic [103:0]      m_tdata
);
	localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int VW = $clog2(VIRT_PAGES);
	localparam int FW = $clog2(FRAMES);
	localparam int SW = TW + VW;
	localparam int SLOTS = TASKS * VIRT_PAGES;
	localparam int OW = $clog2(PAGE_BYTES);
	localparam int PW = $clog2(MAX_REQ_PAGES + 1);
	localparam int CLR = (SLOTS > FRAMES) ? SLOTS : FRAMES;
	localparam int CW = $clog2(CLR + 1);
	localparam int LW = 21 - OW + 1;

	ptda_pkg::state_t state_q;
	logic [CW-1:0] clr_q;
	logic [TW-1:0] task_q;
	logic [VW-1:0] page_q;
	logic [PW-1:0] left_q, pages_q;
	logic [8:0] hits_q, mapped_q, failed_q;
	logic [FW:0] free_q, scan_q;
	logic out_v_q;
	logic [103:0] out_q;

	logic [3:0] in_task;
	logic [31:0] in_addr;
	logic [20:0] in_len;
	logic [LW-1:0] len_pages;
	logic [PW-1:0] capped;
	assign in_task = s_tdata[3:0];
	assign in_addr = s_tdata[35:4];
	assign in_len = s_tdata[56:36];
	assign len_pages = LW'(in_len >> OW) + LW'(|in_len[OW-1:0]);
	assign capped = (len_pages > LW'(MAX_REQ_PAGES)) ? PW'(MAX_REQ_PAGES) : PW'(len_pages);

	// Memories: valid bit per slot, free bit per frame, totals per task.
	logic v_we, v_wd, v_rd, f_we, f_wd, f_rd, t_we;
	logic [SW-1:0] v_wa;
	logic [FW-1:0] f_wa, f_ra;
	logic [63:0] t_rd;
	logic [SW-1:0] slot;
	logic [TW-1:0] t_wa;
	logic [63:0] t_wd;
	logic [31:0] ha, pa, ha_sat, pa_sat;
	logic clearing;
	assign slot = {task_q, page_q};
	assign clearing = (state_q == ptda_pkg::ST_CLEAR);

	assign ha = t_rd[31:0] + 32'(hits_q);
	assign pa = t_rd[63:32] + 32'(pages_q);
	assign ha_sat = (ha < t_rd[31:0]) ? ptda_pkg::SAT32 : ha;
	assign pa_sat = (pa < t_rd[63:32]) ? ptda_pkg::SAT32 : pa;
	assign t_wa = clearing ? clr_q[TW-1:0] : task_q;
	assign t_wd = clearing ? 64'b0 : {pa_sat, ha_sat};

	ptda_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_valid (.clk(clk), .we(v_we), .waddr(v_wa),
		.wdata(v_wd), .raddr(slot), .rdata(v_rd));
	ptda_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_free (.clk(clk), .we(f_we), .waddr(f_wa),
		.wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
	ptda_ram #(.WIDTH(64), .DEPTH(TASKS)) u_tot (.clk(clk), .we(t_we), .waddr(t_wa),
		.wdata(t_wd), .raddr(task_q), .rdata(t_rd));

	// Free-map scan reads frame scan_q; a hit consumes it.
	assign f_ra = scan_q[FW-1:0];
	always_comb begin
		v_we = 1'b0;
		v_wd = 1'b0;
		v_wa = slot;
		f_we = 1'b0;
		f_wd = 1'b0;
		f_wa = scan_q[FW-1:0];
		t_we = 1'b0;
		if (clearing) begin
			v_we = (clr_q < CW'(SLOTS));
			v_wa = clr_q[SW-1:0];
			f_we = (clr_q < CW'(FRAMES));
			f_wd = 1'b1;
			f_wa = clr_q[FW-1:0];
			t_we = (clr_q < CW'(TASKS));
		end else if (state_q == ptda_pkg::ST_SCAN && f_rd) begin
			v_we = 1'b1;
			v_wd = 1'b1;
			f_we = 1'b1;
		end else if (state_q == ptda_pkg::ST_DONE) begin
			t_we = 1'b1;
		end
	end

	assign s_tready = (state_q == ptda_pkg::ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptda_pkg::ST_CLEAR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			free_q <= (FW+1)'(FRAMES);
			scan_q <= '0;
			left_q <= '0;
			hits_q <= '0;
			mapped_q <= '0;
			failed_q <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ptda_pkg::ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR - 1)) state_q <= ptda_pkg::ST_IDLE;
				end
				ptda_pkg::ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						hits_q <= '0;
						mapped_q <= '0;
						failed_q <= '0;
						task_q <= in_task[TW-1:0];
						page_q <= VW'(in_addr >> OW);
						if (32'(in_task) >= 32'(TASKS)) begin
							out_q <= {4'b0, 9'(free_q), 91'b0};
							out_v_q <= 1'b1;
						end else begin
							left_q <= capped;
							pages_q <= capped;
							state_q <= (capped == '0) ? ptda_pkg::ST_TOTAL : ptda_pkg::ST_READ;
						end
					end
				end
				ptda_pkg::ST_READ: state_q <= ptda_pkg::ST_PAGE;
				ptda_pkg::ST_PAGE: begin
					if (v_rd) begin
						hits_q <= hits_q + 9'd1;
						left_q <= left_q - PW'(1);
						page_q <= page_q + VW'(1);
						state_q <= (left_q == PW'(1)) ? ptda_pkg::ST_TOTAL : ptda_pkg::ST_READ;
					end else if (free_q == '0) begin
						failed_q <= failed_q + 9'd1;
						left_q <= left_q - PW'(1);
						page_q <= page_q + VW'(1);
						state_q <= (left_q == PW'(1)) ? ptda_pkg::ST_TOTAL : ptda_pkg::ST_READ;
					end else begin
						state_q <= ptda_pkg::ST_SCAN;
					end
				end
				ptda_pkg::ST_SCAN: begin
					// scan_q never passes a free frame, so a frame is found below FRAMES.
					if (f_rd) begin
						mapped_q <= mapped_q + 9'd1;
						free_q <= free_q - (FW+1)'(1);
						scan_q <= scan_q + (FW+1)'(1);
						left_q <= left_q - PW'(1);
						page_q <= page_q + VW'(1);
						state_q <= (left_q == PW'(1)) ? ptda_pkg::ST_TOTAL : ptda_pkg::ST_READ;
					end else begin
						scan_q <= scan_q + (FW+1)'(1);
						state_q <= ptda_pkg::ST_PAGE;
					end
				end
				ptda_pkg::ST_TOTAL: state_q <= ptda_pkg::ST_DONE;
				ptda_pkg::ST_DONE: begin
					out_q <= {4'b0, 9'(free_q), pa_sat, ha_sat, failed_q, mapped_q, hits_q};
					out_v_q <= 1'b1;
					state_q <= ptda_pkg::ST_IDLE;
				end
				default: state_q <= ptda_pkg::ST_IDLE;
			endcase
		end
	end

	`PTDA_ASSERT(a_free_range, clk, arst_n, free_q <= (FW+1)'(FRAMES), "free count too large")
	`PTDA_ASSERT(a_counts, clk, arst_n,
		(10'(hits_q) + 10'(mapped_q) + 10'(failed_q)) <= 10'(MAX_REQ_PAGES),
		"page counts exceed request")
	`PTDA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid,
		"result dropped")
endmodule
`default_nettype wire

// ===== sim/page_table_demand_allocator_checker.sv =====
// Checker for the page table allocator: predicts each result and compares it.
`timescale 1ns / 100ps
`default_nettype none
module page_table_demand_allocator_checker (
	input  wire logic         clk,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	// task_num, virt_address, byte_length, zero fill
	input  wire logic [63:0]  s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	// hit_pages, mapped_pages, failed_pages, task_hit_total, task_page_total, frames_left
	input  wire logic [103:0] m_tdata,
	output int                fail_count,
	output int                pending
);
	typedef struct packed {
		logic [8:0]  frames_left;
		logic [31:0] task_page_total;
		logic [31:0] task_hit_total;
		logic [8:0]  failed_pages;
		logic [8:0]  mapped_pages;
		logic [8:0]  hit_pages;
	} alloc_result_t;

	bit            page_mapped [ptda_pkg::TASKS*ptda_pkg::VIRT_PAGES];
	bit            frame_avail [ptda_pkg::FRAMES];
	logic [31:0]   hits_total [ptda_pkg::TASKS];
	logic [31:0]   pages_total [ptda_pkg::TASKS];
	int            frames_free;
	alloc_result_t expected_allocs [$];

	function automatic logic [31:0] add_saturating(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? ptda_pkg::SAT32 : s[31:0];
	endfunction

	function automatic alloc_result_t allocate_pages(logic [3:0] tsk, logic [31:0] addr,
			logic [20:0] len);
		alloc_result_t r;
		int npages;
		int start;
		int slot;
		int f;
		bit got;
		r = '0;
		npages = (len + ptda_pkg::PAGE_BYTES - 1) / ptda_pkg::PAGE_BYTES;
		if (npages > ptda_pkg::MAX_REQ_PAGES)
			npages = ptda_pkg::MAX_REQ_PAGES;
		start = (addr / ptda_pkg::PAGE_BYTES) % ptda_pkg::VIRT_PAGES;
		for (int i = 0; i < npages; i++) begin
			slot = tsk * ptda_pkg::VIRT_PAGES + (start + i) % ptda_pkg::VIRT_PAGES;
			if (page_mapped[slot]) begin
				r.hit_pages++;
			end else begin
				got = 0;
				for (f = 0; f < ptda_pkg::FRAMES && !got; f++) begin
					if (frame_avail[f]) begin
						frame_avail[f] = 0;
						frames_free--;
						got = 1;
					end
				end
				if (got) begin
					page_mapped[slot] = 1;
					r.mapped_pages++;
				end else begin
					r.failed_pages++;
				end
			end
		end
		hits_total[tsk] = add_saturating(hits_total[tsk], 32'(r.hit_pages));
		pages_total[tsk] = add_saturating(pages_total[tsk], 32'(npages));
		r.task_hit_total = hits_total[tsk];
		r.task_page_total = pages_total[tsk];
		r.frames_left = 9'(frames_free);
		return r;
	endfunction

	initial begin
		foreach (page_mapped[i]) page_mapped[i] = 0;
		foreach (frame_avail[i]) frame_avail[i] = 1;
		foreach (hits_total[i]) begin
			hits_total[i] = '0;
			pages_total[i] = '0;
		end
		frames_free = ptda_pkg::FRAMES;
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (s_tvalid && s_tready)
			expected_allocs.push_back(allocate_pages(s_tdata[3:0], s_tdata[35:4],
				s_tdata[56:36]));
		if (m_tvalid && m_tready) begin
			got = m_tdata[99:0];
			if (expected_allocs.size() == 0) begin
				$error("result transfer with no request outstanding");
				fail_count++;
			end else begin
				want = expected_allocs.pop_front();
				if (got.hit_pages !== want.hit_pages) begin
					$error("hit_pages: expected %0d, got %0d", want.hit_pages, got.hit_pages);
					fail_count++;
				end
				if (got.mapped_pages !== want.mapped_pages) begin
					$error("mapped_pages: expected %0d, got %0d", want.mapped_pages,
						got.mapped_pages);
					fail_count++;
				end
				if (got.failed_pages !== want.failed_pages) begin
					$error("failed_pages: expected %0d, got %0d", want.failed_pages,
						got.failed_pages);
					fail_count++;
				end
				if (got.task_hit_total !== want.task_hit_total) begin
					$error("task_hit_total: expected %0d, got %0d", want.task_hit_total,
						got.task_hit_total);
					fail_count++;
				end
				if (got.task_page_total !== want.task_page_total) begin
					$error("task_page_total: expected %0d, got %0d", want.task_page_total,
						got.task_page_total);
					fail_count++;
				end
				if (got.frames_left !== want.frames_left) begin
					$error("frames_left: expected %0d, got %0d", want.frames_left,
						got.frames_left);
					fail_count++;
				end
			end
		end
		pending = expected_allocs.size();
	end
endmodule
`default_nettype wire

// ===== sim/tb_page_table_demand_allocator.sv =====
// Testbench top for the page table allocator: stimulus, stalls and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_page_table_demand_allocator;
	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [103:0] m_tdata;
	int           fail_count;
	int           pending;
	int           burst_left = 0;
	bit           sending_done = 0;

	page_table_demand_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	page_table_demand_allocator_checker u_checker (
		.clk(clk), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always #4 clk = ~clk;

	// The receiver alternates between stretches of full readiness and random stalls.
	int stall_mode = 0;
	int mode_left = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(5, 200);
		end
		mode_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Presents one request; valid stays high across back-to-back items within a burst.
	task automatic send_request(logic [3:0] tsk, logic [31:0] addr, logic [20:0] len);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid = 0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid = 1;
		s_tdata = {7'b0, len, addr, tsk};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(0, 9) != 0)
			a[21:12] = 10'($urandom_range(0, 31));
		return a;
	endfunction

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;

		// Short directed part: length edges, task extremes, repeat hits, wrap at the top.
		send_request(4'd0, 32'h0000_0000, 21'd0);
		send_request(4'd0, 32'h0000_0000, 21'd1);
		send_request(4'd0, 32'h0000_0FFF, 21'd1);
		send_request(4'd0, 32'h0000_0000, 21'd4096);
		send_request(4'd0, 32'h0000_0800, 21'd4097);
		send_request(4'd15, 32'hFFFF_FFFF, 21'd8192);
		send_request(4'd15, 32'h003F_F000, 21'd12288);
		send_request(4'd15, 32'hFFC0_1000, 21'd0);
		send_request(4'd7, 32'hAAAA_AAAA, 21'h0F_FFFF);
		send_request(4'd7, 32'h5555_5555, 21'd4095);
		send_request(4'd7, 32'hAAAA_AAAA, 21'd20000);

		// Random part: mostly short requests on a small page window so hits occur.
		for (int n = 0; n < 1800; n++) begin
			logic [20:0] len;
			if (n > 1500 && $urandom_range(0, 19) == 0)
				len = 21'($urandom_range(0, 1048576));
			else
				len = 21'($urandom_range(0, 6 * 4096));
			send_request(4'($urandom_range(0, 15)), pick_address(), len);
		end

		// Overlong requests run the frame pool dry and then mostly fail.
		send_request(4'd3, 32'hFFFF_F000, 21'd1048576);
		send_request(4'd4, 32'h1234_5678, 21'd1048576);
		send_request(4'd3, 32'hFFFF_F000, 21'd1048576);

		s_tvalid = 0;
		sending_done = 1;
	end

	initial begin
		wait (sending_done);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(8 * 20_000_000);
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
